// File: hdl/sqlts_pkg.sv
`default_nettype none

package sqlts_pkg;

   // One input word: a text byte, or the end-of-statement marker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_marker;
   } req_word_type;

   // One result word: a token descriptor.
   typedef struct packed {
      logic [2:0]  token_kind;
      logic [2:0]  keyword_code;
      logic [15:0] start_offset;
      logic [15:0] text_length;
      logic [7:0]  single_byte;
      logic        last_of_run;
   } rsp_word_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUM,
      MODE_STR
   } scan_mode_type;

   // Up to two result words per input word travel to the result queue together.
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type slot1;
      rsp_word_type slot0;
   } push_type;

   localparam logic [2:0] KIND_KEYWORD    = 3'd0;
   localparam logic [2:0] KIND_IDENTIFIER = 3'd1;
   localparam logic [2:0] KIND_NUMBER     = 3'd2;
   localparam logic [2:0] KIND_STRING     = 3'd3;
   localparam logic [2:0] KIND_SYMBOL     = 3'd4;
   localparam logic [2:0] KIND_UNKNOWN    = 3'd5;
   localparam logic [2:0] KIND_END        = 3'd6;

   localparam logic [2:0] KW_NONE = 3'd0;

   localparam logic [7:0] BYTE_QUOTE_SINGLE = 8'h27;
   localparam logic [7:0] BYTE_QUOTE_DOUBLE = 8'h22;
   localparam logic [7:0] BYTE_UNDERSCORE   = 8'h5F;

   localparam int KW_COUNT = 6;

   // Keyword spellings in upper case, padded with zeros to eight bytes.
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{8'h49, 8'h4E, 8'h53, 8'h45, 8'h52, 8'h54, 8'h00, 8'h00},  // INSERT
      '{8'h53, 8'h45, 8'h4C, 8'h45, 8'h43, 8'h54, 8'h00, 8'h00},  // SELECT
      '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00},  // DELETE
      '{8'h46, 8'h52, 8'h4F, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00},  // FROM
      '{8'h49, 8'h4E, 8'h54, 8'h4F, 8'h00, 8'h00, 8'h00, 8'h00},  // INTO
      '{8'h56, 8'h41, 8'h4C, 8'h55, 8'h45, 8'h53, 8'h00, 8'h00}   // VALUES
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd6, 3'd6, 3'd4, 3'd4, 3'd6};

   // Keeps those keyword candidates whose letter at position idx matches
   // the byte, ignoring case. idx_ok is low once the word is too long.
   function automatic logic [KW_COUNT-1:0] filter_kw(input logic [KW_COUNT-1:0] cands,
                                                     input logic idx_ok,
                                                     input logic [2:0] idx,
                                                     input logic [7:0] b);
      logic [7:0]          up;
      logic [KW_COUNT-1:0] keep;
      up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
      for (int k = 0; k < KW_COUNT; k++) begin
         keep[k] = cands[k] && idx_ok && (idx < KW_LEN[k]) && (KW_TEXT[k][idx] == up);
      end
      return keep;
   endfunction

endpackage

`default_nettype wire

// File: hdl/sqlts_scan.sv
`default_nettype none

module sqlts_scan #(
   parameter int unsigned OFFSET_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sqlts_pkg::req_word_type req_word,
   input  logic                    room,
   output sqlts_pkg::push_type     push
);
   import sqlts_pkg::*;

   localparam logic [OFFSET_BITS-1:0] ONE = OFFSET_BITS'(1);

   logic                    in_valid_ff, in_valid_in;
   req_word_type            in_word_ff;
   scan_mode_type           mode_ff, mode_in;
   logic                    quote_dbl_ff, quote_dbl_in;
   logic [OFFSET_BITS-1:0]  start_ff, start_in;
   logic [OFFSET_BITS-1:0]  length_ff, length_in;
   logic [KW_COUNT-1:0]     cands_ff, cands_in;
   logic [OFFSET_BITS-1:0]  pos_ff, pos_in;

   logic                    take;
   logic [7:0]              b;
   logic                    eom;
   logic                    is_space, is_alpha, is_digit, is_quote, is_punct;
   logic                    cont, flush, fresh, other_present;
   logic [1:0]              n_results;
   rsp_word_type            flush_res, other_res;

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (&v) ? v : v + ONE;
   endfunction

   function automatic logic [15:0] clamp16(input logic [OFFSET_BITS-1:0] v);
      logic [OFFSET_BITS+15:0] ext;
      ext = {16'b0, v};
      return (ext[OFFSET_BITS+15:16] != '0) ? 16'hFFFF : ext[15:0];
   endfunction

   assign take      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
   end

   // Byte classification.
   assign b        = in_word_ff.data_byte;
   assign eom      = in_word_ff.end_marker;
   assign is_space = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   assign is_alpha = (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
   assign is_digit = (b >= 8'd48 && b <= 8'd57);
   assign is_quote = (b == BYTE_QUOTE_SINGLE) || (b == BYTE_QUOTE_DOUBLE);
   assign is_punct = !is_quote &&
                     ((b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
                      (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126));

   // Decisions shared by the next-state and result logic.
   always_comb begin
      unique case (mode_ff)
         MODE_WORD: cont = is_alpha || is_digit || (b == BYTE_UNDERSCORE);
         MODE_NUM:  cont = is_digit;
         MODE_STR:  cont = (b != (quote_dbl_ff ? BYTE_QUOTE_DOUBLE : BYTE_QUOTE_SINGLE));
         default:   cont = 1'b0;
      endcase
      if (eom) begin
         flush = (mode_ff != MODE_IDLE);
         fresh = 1'b0;
      end else begin
         flush = (mode_ff != MODE_IDLE) && !cont;
         fresh = (mode_ff == MODE_IDLE) ||
                 (((mode_ff == MODE_WORD) || (mode_ff == MODE_NUM)) && !cont);
      end
      other_present = eom || (fresh && !is_space && !is_alpha && !is_digit && !is_quote);
      n_results     = {1'b0, flush} + {1'b0, other_present};
   end

   // Next state.
   always_comb begin
      mode_in      = mode_ff;
      quote_dbl_in = quote_dbl_ff;
      start_in     = start_ff;
      length_in    = length_ff;
      cands_in     = cands_ff;
      pos_in       = sat_inc(pos_ff);
      if (eom) begin
         mode_in      = MODE_IDLE;
         quote_dbl_in = 1'b0;
         start_in     = '0;
         length_in    = '0;
         cands_in     = '1;
         pos_in       = '0;
      end else if (fresh) begin
         mode_in = MODE_IDLE;
         if (is_alpha) begin
            mode_in   = MODE_WORD;
            start_in  = pos_ff;
            length_in = ONE;
            cands_in  = filter_kw('1, 1'b1, 3'd0, b);
         end else if (is_digit) begin
            mode_in   = MODE_NUM;
            start_in  = pos_ff;
            length_in = ONE;
         end else if (is_quote) begin
            mode_in      = MODE_STR;
            quote_dbl_in = (b == BYTE_QUOTE_DOUBLE);
            start_in     = sat_inc(pos_ff);
            length_in    = '0;
         end
      end else if (flush) begin
         mode_in = MODE_IDLE;
      end else if (cont) begin
         if (mode_ff == MODE_WORD) begin
            cands_in = filter_kw(cands_ff, length_ff < OFFSET_BITS'(6), length_ff[2:0], b);
         end
         length_in = sat_inc(length_ff);
      end
   end

   // Result words.
   always_comb begin
      flush_res              = '0;
      flush_res.start_offset = clamp16(start_ff);
      flush_res.text_length  = clamp16(length_ff);
      unique case (mode_ff)
         MODE_WORD: begin
            flush_res.token_kind   = KIND_IDENTIFIER;
            flush_res.keyword_code = KW_NONE;
            for (int k = 0; k < KW_COUNT; k++) begin
               if (cands_ff[k] && (length_ff == OFFSET_BITS'(KW_LEN[k]))) begin
                  flush_res.token_kind   = KIND_KEYWORD;
                  flush_res.keyword_code = 3'(k + 1);
               end
            end
         end
         MODE_NUM: flush_res.token_kind = KIND_NUMBER;
         MODE_STR: flush_res.token_kind = KIND_STRING;
         default:  flush_res.token_kind = KIND_END;
      endcase

      other_res              = '0;
      other_res.start_offset = clamp16(pos_ff);
      other_res.last_of_run  = 1'b1;
      if (eom) begin
         other_res.token_kind = KIND_END;
      end else begin
         other_res.token_kind  = is_punct ? KIND_SYMBOL : KIND_UNKNOWN;
         other_res.text_length = 16'd1;
         other_res.single_byte = b;
      end

      push       = '0;
      push.count = take ? n_results : 2'd0;
      push.slot1 = other_res;
      if (flush) begin
         push.slot0             = flush_res;
         push.slot0.last_of_run = !other_present;
      end else begin
         push.slot0 = other_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         quote_dbl_ff <= 1'b0;
         start_ff     <= '0;
         length_ff    <= '0;
         cands_ff     <= '1;
         pos_ff       <= '0;
      end else if (take) begin
         mode_ff      <= mode_in;
         quote_dbl_ff <= quote_dbl_in;
         start_ff     <= start_in;
         length_ff    <= length_in;
         cands_ff     <= cands_in;
         pos_ff       <= pos_in;
      end
   end

`ifndef SYNTH
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      take && eom |=> (pos_ff == '0) && (mode_ff == MODE_IDLE))
      else $error("end marker did not restart the scanner");
   a_end_reports: assert property (@(posedge clock) disable iff (reset)
      take && eom |-> (push.count != 2'd0))
      else $error("end marker produced no result");
   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.slot0.last_of_run && push.slot1.last_of_run)
      else $error("last_of_run misplaced on a two-result word");
`endif

endmodule

`default_nettype wire

// File: hdl/sqlts_rsp_queue.sv
`default_nettype none

module sqlts_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  sqlts_pkg::push_type     push,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sqlts_pkg::rsp_word_type rsp_word
);
   import sqlts_pkg::*;

   rsp_word_type entry_ff [4];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;

   // Room for two words is offered regardless of a pop in the same cycle.
   assign room      = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.slot1;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overfilled");
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= 3'd2)
      else $error("push into a queue without room");
   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rd_ptr_ff))
      else $error("stalled result word was lost");
`endif

endmodule

`default_nettype wire

// File: hdl/sql_token_scanner.sv
`default_nettype none

// SQL token scanner. Statement text arrives one byte per input word; a word
// with end_marker set closes the statement, flushes any open token, reports
// end of input and restarts byte offsets at zero. Whitespace is skipped, and
// each token comes out as one result word carrying its kind, keyword code,
// start offset, length and, for symbols and unknown bytes, the byte itself.
// One input word is accepted per clock cycle while the queue has room. A
// word yields zero, one or two result words; the result channel delivers
// one word per cycle while rsp_ready is high, so the sustained input rate
// is one byte per cycle as long as each byte yields at most one result
// word. A byte that both ends a word or number and is itself a symbol or
// an unknown byte, and an end marker that closes an open token, each yield
// two result words. The input stalls while the result queue holds more than
// two words. A byte passes through the input register and the scan
// logic into a four-word result queue. Offsets and lengths saturate at
// 2^OFFSET_BITS-1 internally and at 65535 on the ports.
module sql_token_scanner #(
   parameter int unsigned OFFSET_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sqlts_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sqlts_pkg::rsp_word_type rsp_word
);
   import sqlts_pkg::*;

   push_type push;
   logic     room;

   // Classification, token state and result formation for one byte.
   sqlts_scan #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .room      (room),
      .push      (push)
   );

   // Result queue: absorbs two words at once and hands them out one per cycle while rsp_ready is high.
   sqlts_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
